FILE: src/cmli_pkg.sv
// Shared types and constants for the colormap linear interpolator.
`timescale 1ns / 1ps
`default_nettype none

package cmli_pkg;

    localparam int COLOR_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 4;
    localparam int VALUE_W   = 18;
    localparam int INDEX_W   = 4;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_COUNT = 2'd0,
        REG_BELOW      = 2'd1,
        REG_ABOVE      = 2'd2
    } t_cfg_reg;

    // How the final color of a map beat is chosen.
    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_BELOW,
        CLS_ABOVE,
        CLS_STOP,
        CLS_BLEND
    } t_cls;

    // Control that travels with a beat from stage to stage.
    typedef struct packed {
        logic valid;
        logic wr;
        t_cls cls;
    } t_ctl;

endpackage

`default_nettype wire

FILE: src/cmli_front.sv
// Second pipeline stage: classification of the sample and segment position multiply.
`timescale 1ns / 1ps
`default_nettype none

module cmli_front #(
    parameter int MAX_STOPS       = 16,
    parameter int VALUE_FRAC_BITS = 16,
    parameter int NW              = $clog2(MAX_STOPS + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic                                i_func,
    input  wire logic signed [cmli_pkg::VALUE_W-1:0] i_value,
    input  wire logic [cmli_pkg::INDEX_W-1:0]        i_index,
    input  wire logic [cmli_pkg::COLOR_W-1:0]        i_color,
    input  wire logic [cmli_pkg::COUNT_W-1:0]        i_stop_count,
    input  wire logic                                i_next_en,
    output logic                                     o_en,
    output cmli_pkg::t_ctl                           o_ctl,
    output logic [VALUE_FRAC_BITS+NW-1:0]            o_pos,
    output logic [NW-1:0]                            o_last,
    output logic [cmli_pkg::INDEX_W-1:0]             o_index,
    output logic [cmli_pkg::COLOR_W-1:0]             o_color
);
    import cmli_pkg::*;

    localparam int F    = VALUE_FRAC_BITS;
    localparam int PW   = F + NW;
    localparam int CMPW = (F + 2 > VALUE_W) ? F + 2 : VALUE_W;
    localparam int CW   = (NW > COUNT_W) ? NW : COUNT_W;
    localparam logic [CMPW-1:0] ONE_X = {{(CMPW - F - 1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic [CW-1:0]   MAX_X = CW'(MAX_STOPS);

    t_ctl             r_ctl;
    logic [PW-1:0]    r_pos;
    logic [NW-1:0]    r_last;
    logic [INDEX_W-1:0] r_index;
    logic [COLOR_W-1:0] r_color;

    logic [CW-1:0]    count_x;
    logic [NW-1:0]    n_stops;
    logic [NW-1:0]    n_last;
    logic [CMPW-1:0]  value_x;
    logic             le_zero;
    logic             ge_one;
    t_cls             n_cls;
    logic [PW-1:0]    n_pos;

    assign o_en = !r_ctl.valid || i_next_en;

    always_comb begin
        count_x = CW'(i_stop_count);
        if (count_x > MAX_X) begin
            n_stops = NW'(MAX_STOPS);
        end else begin
            n_stops = count_x[NW-1:0];
        end
        n_last  = n_stops - NW'(1);
        value_x = CMPW'($unsigned(i_value));
        le_zero = i_value[VALUE_W-1] || (i_value == '0);
        // Only meaningful for a positive sample, which is the only case that reaches it.
        ge_one  = value_x >= ONE_X;

        if (n_stops == '0) begin
            n_cls = CLS_ZERO;
        end else if (le_zero) begin
            n_cls = CLS_BELOW;
        end else if (ge_one) begin
            n_cls = CLS_ABOVE;
        end else if (n_stops == NW'(1)) begin
            n_cls = CLS_STOP;
        end else begin
            n_cls = CLS_BLEND;
        end

        n_pos = PW'(value_x[F-1:0]) * PW'(n_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{valid: 1'b0, wr: 1'b0, cls: CLS_ZERO};
        end else if (o_en) begin
            r_ctl <= '{valid: i_valid, wr: i_func, cls: n_cls};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_pos   <= n_pos;
            r_last  <= n_last;
            r_index <= i_index;
            r_color <= i_color;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_pos   = r_pos;
    assign o_last  = r_last;
    assign o_index = r_index;
    assign o_color = r_color;

endmodule

`default_nettype wire

FILE: src/cmli_table.sv
// Third pipeline stage: stop table memory with one write port and two read ports.
`timescale 1ns / 1ps
`default_nettype none

module cmli_table #(
    parameter int MAX_STOPS       = 16,
    parameter int VALUE_FRAC_BITS = 16,
    parameter int NW              = $clog2(MAX_STOPS + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  cmli_pkg::t_ctl                    i_ctl,
    input  wire logic [VALUE_FRAC_BITS+NW-1:0] i_pos,
    input  wire logic [NW-1:0]                i_last,
    input  wire logic [cmli_pkg::INDEX_W-1:0] i_index,
    input  wire logic [cmli_pkg::COLOR_W-1:0] i_color,
    input  wire logic                         i_next_en,
    output logic                              o_en,
    output cmli_pkg::t_ctl                    o_ctl,
    output logic [cmli_pkg::COLOR_W-1:0]      o_ca,
    output logic [cmli_pkg::COLOR_W-1:0]      o_cb,
    output logic [VALUE_FRAC_BITS-1:0]        o_frac
);
    import cmli_pkg::*;

    localparam int F  = VALUE_FRAC_BITS;
    localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int IW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

    logic [COLOR_W-1:0] mem [MAX_STOPS];

    t_ctl               r_ctl;
    logic [COLOR_W-1:0] r_ca;
    logic [COLOR_W-1:0] r_cb;
    logic [F-1:0]       r_frac;

    logic [NW-1:0]      seg;
    logic [AW-1:0]      rd_a;
    logic [AW-1:0]      rd_b;
    logic [IW-1:0]      index_x;
    logic               wr_ok;

    assign o_en = !r_ctl.valid || i_next_en;

    always_comb begin
        seg = i_pos[F+NW-1:F];
        // The segment cannot pass the last pair for a sample below one; kept as a guard.
        if (seg >= i_last) begin
            seg = i_last - NW'(1);
        end
        if (i_ctl.cls == CLS_STOP) begin
            rd_a = '0;
        end else begin
            rd_a = seg[AW-1:0];
        end
        rd_b    = rd_a + AW'(1);
        index_x = IW'(i_index);
        wr_ok   = index_x < IW'(MAX_STOPS);
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_ctl.valid && i_ctl.wr && wr_ok) begin
            mem[index_x[AW-1:0]] <= i_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_ca   <= mem[rd_a];
            r_cb   <= mem[rd_b];
            r_frac <= i_pos[F-1:0];
        end
    end

    // Stop writes end here; only map beats go on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{valid: 1'b0, wr: 1'b0, cls: CLS_ZERO};
        end else if (o_en) begin
            r_ctl <= '{valid: i_ctl.valid && !i_ctl.wr, wr: 1'b0, cls: i_ctl.cls};
        end
    end

    assign o_ctl  = r_ctl;
    assign o_ca   = r_ca;
    assign o_cb   = r_cb;
    assign o_frac = r_frac;

endmodule

`default_nettype wire

FILE: src/cmli_blend.sv
// Fourth pipeline stage: per-channel blend lanes, color selection and output register.
`timescale 1ns / 1ps
`default_nettype none

module cmli_blend #(
    parameter int VALUE_FRAC_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  cmli_pkg::t_ctl                    i_ctl,
    input  wire logic [cmli_pkg::COLOR_W-1:0] i_ca,
    input  wire logic [cmli_pkg::COLOR_W-1:0] i_cb,
    input  wire logic [VALUE_FRAC_BITS-1:0]   i_frac,
    input  wire logic [cmli_pkg::COLOR_W-1:0] i_below,
    input  wire logic [cmli_pkg::COLOR_W-1:0] i_above,
    input  wire logic                         i_out_stall,
    output logic                              o_en,
    output logic                              o_valid,
    output logic [cmli_pkg::COLOR_W-1:0]      o_rgba
);
    import cmli_pkg::*;

    localparam int F  = VALUE_FRAC_BITS;
    localparam int MW = F + CHAN_W + 1;
    localparam int SW = MW + 1;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic               r_valid;
    logic [COLOR_W-1:0] r_rgba;

    logic [F:0]         frac_inv;
    logic [SW-1:0]      lane_sum [NUM_CHAN];
    logic [COLOR_W-1:0] mixed;
    logic [COLOR_W-1:0] n_rgba;

    assign o_en = !r_valid || !i_out_stall;

    always_comb begin
        frac_inv = ONE - (F + 1)'(i_frac);
        for (int k = 0; k < NUM_CHAN; k++) begin
            lane_sum[k] = SW'(MW'(i_ca[k*CHAN_W +: CHAN_W]) * MW'(frac_inv))
                        + SW'(MW'(i_cb[k*CHAN_W +: CHAN_W]) * MW'(i_frac));
            mixed[k*CHAN_W +: CHAN_W] = lane_sum[k][F +: CHAN_W];
        end
    end

    always_comb begin
        unique case (i_ctl.cls)
            CLS_ZERO:  n_rgba = '0;
            CLS_BELOW: n_rgba = i_below;
            CLS_ABOVE: n_rgba = i_above;
            CLS_STOP:  n_rgba = i_ca;
            CLS_BLEND: n_rgba = mixed;
            default:   n_rgba = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_rgba <= n_rgba;
        end
    end

    assign o_valid = r_valid;
    assign o_rgba  = r_rgba;

endmodule

`default_nettype wire

FILE: src/colormap_linear_interpolator.sv
// Top level of the colormap linear interpolator: input stage, registers and pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Maps a signed fixed-point sample (VALUE_FRAC_BITS fraction bits) to an RGBA color by
// linear interpolation between up to MAX_STOPS equally spaced stops held in a small table.
// A beat with i_func high writes one stop if its index is below MAX_STOPS and yields no
// result; a beat with i_func low yields exactly one color. Samples at or below zero give
// the below color, samples at or above one give the above color, a stop count of zero
// gives black with zero alpha, and a count of one gives stop zero. The block takes one
// beat per clock while the output is not stalled and passes it through four register
// stages: input register, classification and segment multiply, table read, then blend
// and output register. Stops are written in the third stage, so a map beat right behind
// a stop write already sees the new stop. Table entries have no reset value; reading a
// stop that was never written returns whatever the memory holds. Configuration registers
// should be written only when no beat is in flight.
module colormap_linear_interpolator #(
    parameter int MAX_STOPS       = 16,
    parameter int VALUE_FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [cmli_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [cmli_pkg::COLOR_W-1:0]        i_cfg_data,
    // Input channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_func,
    input  wire logic signed [cmli_pkg::VALUE_W-1:0] i_map_value,
    input  wire logic [cmli_pkg::INDEX_W-1:0]        i_stop_index,
    input  wire logic [cmli_pkg::COLOR_W-1:0]        i_stop_color,
    // Output channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [cmli_pkg::CHAN_W-1:0]              o_red,
    output logic [cmli_pkg::CHAN_W-1:0]              o_green,
    output logic [cmli_pkg::CHAN_W-1:0]              o_blue,
    output logic [cmli_pkg::CHAN_W-1:0]              o_alpha
);
    import cmli_pkg::*;

    localparam int NW = $clog2(MAX_STOPS + 1);
    localparam int PW = VALUE_FRAC_BITS + NW;

    // Configuration registers.
    logic [COUNT_W-1:0] r_stop_count;
    logic [COLOR_W-1:0] r_below;
    logic [COLOR_W-1:0] r_above;

    // Input register stage.
    logic                       r1_valid;
    logic                       r1_func;
    logic signed [VALUE_W-1:0]  r1_value;
    logic [INDEX_W-1:0]         r1_index;
    logic [COLOR_W-1:0]         r1_color;
    logic                       s1_en;

    // Links between the pipeline stages.
    logic               s2_en;
    t_ctl               s2_ctl;
    logic [PW-1:0]      s2_pos;
    logic [NW-1:0]      s2_last;
    logic [INDEX_W-1:0] s2_index;
    logic [COLOR_W-1:0] s2_color;

    logic               s3_en;
    t_ctl               s3_ctl;
    logic [COLOR_W-1:0] s3_ca;
    logic [COLOR_W-1:0] s3_cb;
    logic [VALUE_FRAC_BITS-1:0] s3_frac;

    logic               s4_en;
    logic [COLOR_W-1:0] s4_rgba;

    // Register writes. An index with no register behind it is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= '0;
            r_below      <= '0;
            r_above      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STOP_COUNT: r_stop_count <= i_cfg_data[COUNT_W-1:0];
                REG_BELOW:      r_below      <= i_cfg_data;
                REG_ABOVE:      r_above      <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Each stage loads when it is empty or the stage after it moves, so bubbles collapse
    // and the input is stalled only when every stage holds a beat and the output waits.
    assign s1_en      = !r1_valid || s2_en;
    assign o_in_stall = !s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_en) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r1_func  <= i_func;
            r1_value <= i_map_value;
            r1_index <= i_stop_index;
            r1_color <= i_stop_color;
        end
    end

    cmli_front #(
        .MAX_STOPS       (MAX_STOPS),
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
        .NW              (NW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r1_valid),
        .i_func       (r1_func),
        .i_value      (r1_value),
        .i_index      (r1_index),
        .i_color      (r1_color),
        .i_stop_count (r_stop_count),
        .i_next_en    (s3_en),
        .o_en         (s2_en),
        .o_ctl        (s2_ctl),
        .o_pos        (s2_pos),
        .o_last       (s2_last),
        .o_index      (s2_index),
        .o_color      (s2_color)
    );

    cmli_table #(
        .MAX_STOPS       (MAX_STOPS),
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
        .NW              (NW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (s2_ctl),
        .i_pos     (s2_pos),
        .i_last    (s2_last),
        .i_index   (s2_index),
        .i_color   (s2_color),
        .i_next_en (s4_en),
        .o_en      (s3_en),
        .o_ctl     (s3_ctl),
        .o_ca      (s3_ca),
        .o_cb      (s3_cb),
        .o_frac    (s3_frac)
    );

    cmli_blend #(
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
    ) u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (s3_ctl),
        .i_ca        (s3_ca),
        .i_cb        (s3_cb),
        .i_frac      (s3_frac),
        .i_below     (r_below),
        .i_above     (r_above),
        .i_out_stall (i_out_stall),
        .o_en        (s4_en),
        .o_valid     (o_out_valid),
        .o_rgba      (s4_rgba)
    );

    // Packed color: red in the top byte, alpha in the low byte.
    assign o_red   = s4_rgba[3*CHAN_W +: CHAN_W];
    assign o_green = s4_rgba[2*CHAN_W +: CHAN_W];
    assign o_blue  = s4_rgba[1*CHAN_W +: CHAN_W];
    assign o_alpha = s4_rgba[0*CHAN_W +: CHAN_W];

    // The input can only be held back by a full pipe sitting behind a stalled result.
    a_stall_needs_full_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r1_valid && s2_ctl.valid
                        && s3_ctl.valid))
        else $error("input stalled while the pipeline had room");

    // A beat leaving the input register must land in the next stage.
    a_stage1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && s1_en) |=> s2_ctl.valid)
        else $error("beat lost between input register and second stage");

    // A result after an idle output cycle appears only when a map beat sat in the table stage.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(s3_ctl.valid))
        else $error("result produced without a beat behind it");

endmodule

`default_nettype wire
